// ===== sv/ufmt_pkg.sv =====
// ----------------------------------------------------------------------------
// Unsigned decimal formatter package
// Shared beat types, character constants and sequencer states.
// ----------------------------------------------------------------------------
package ufmt_pkg;

	localparam int MaxField  = 64;
	localparam int MaxDigits = 10;
	localparam int DigIdxW   = 4;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [1:0] SIZE_SHORT = 2'd1;

	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	typedef struct packed {
		logic [31:0]       value;
		logic [1:0]        size_mode;
		logic [6:0]        width;
		logic signed [7:0] precision;
		logic              zero_pad;
		logic              left_justify;
	} in_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} out_t;

	typedef struct packed {
		logic               done;
		logic [DigIdxW-1:0] nd;
	} conv_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

endpackage

// ===== sv/unsigned_decimal_field_formatter_top.sv =====
// ----------------------------------------------------------------------------
// Unsigned decimal field formatter
// Formats one unsigned number as a decimal text field, one character a beat.
//
//   Channel | Direction | Payload          | Handshake
//   in      | input     | ufmt_pkg::in_t   | in_valid / in_ready
//   out     | output    | ufmt_pkg::out_t  | out_valid / out_ready
//
// An item is accepted, then the reciprocal multiplier peels one decimal digit
// per cycle (1 to 10 digits), the field is set up, and the emitter gives one
// character per cycle (up to MAX_FIELD) while the output does not stall.
// The input is not ready until the last character is loaded into the output
// register. A zero with precision zero yields no beats and frees the input at
// once. Output stalls hold the emitter in place.
// ----------------------------------------------------------------------------
module unsigned_decimal_field_formatter_top #(
	parameter int MAX_FIELD = ufmt_pkg::MaxField
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ufmt_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output ufmt_pkg::out_t out_data
);

	localparam int LW = $clog2(MAX_FIELD + 1);

	ufmt_pkg::state_t             state_q;
	ufmt_pkg::conv_stat_t         cstat;
	logic                         accept;
	logic                         skip;
	logic                         has_prec;
	logic [31:0]                  masked;
	logic [LW-1:0]                w_sat;
	logic [LW-1:0]                p_sat;
	logic [LW-1:0]                w_q;
	logic [LW-1:0]                p_q;
	logic                         zp_q;
	logic                         lj_q;
	logic                         emit_start;
	logic                         emit_done;
	logic [ufmt_pkg::DigIdxW-1:0] rd_idx;
	logic [3:0]                   rd_digit;

	assign in_ready = (state_q == ufmt_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign has_prec = !in_data.precision[7];
	assign masked   = (in_data.size_mode == ufmt_pkg::SIZE_SHORT) ?
		{16'd0, in_data.value[15:0]} : in_data.value;
	assign w_sat = (7'(in_data.width) > 7'(MAX_FIELD)) ? LW'(MAX_FIELD) : LW'(in_data.width);
	assign p_sat = !has_prec ? '0 :
		((in_data.precision[6:0] > 7'(MAX_FIELD)) ? LW'(MAX_FIELD) :
		LW'(in_data.precision[6:0]));
	assign skip = (masked == 32'd0) && has_prec && (in_data.precision[6:0] == 7'd0);
	assign emit_start = (state_q == ufmt_pkg::ST_CONV) && cstat.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ufmt_pkg::ST_IDLE;
		end else begin
			case (state_q)
				ufmt_pkg::ST_IDLE: begin
					if (accept && !skip) begin
						state_q <= ufmt_pkg::ST_CONV;
					end
				end
				ufmt_pkg::ST_CONV: begin
					if (cstat.done) begin
						state_q <= ufmt_pkg::ST_EMIT;
					end
				end
				ufmt_pkg::ST_EMIT: begin
					if (emit_done) begin
						state_q <= ufmt_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ufmt_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w_q  <= w_sat;
			p_q  <= p_sat;
			zp_q <= in_data.zero_pad;
			lj_q <= in_data.left_justify;
		end
	end

	ufmt_conv u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && !skip),
		.value    (masked),
		.rd_idx   (rd_idx),
		.rd_digit (rd_digit),
		.stat     (cstat)
	);

	ufmt_emit #(
		.MAX_FIELD (MAX_FIELD)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (emit_start),
		.w_sat     (w_q),
		.p_sat     (p_q),
		.zp        (zp_q),
		.lj        (lj_q),
		.nd        (cstat.nd),
		.rd_idx    (rd_idx),
		.rd_digit  (rd_digit),
		.done      (emit_done),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== sv/ufmt_conv.sv =====
// ----------------------------------------------------------------------------
// Decimal digit converter
// Peels one decimal digit per cycle with a shared reciprocal multiplier.
// ----------------------------------------------------------------------------
module ufmt_conv (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [31:0]                  value,
	input  logic [ufmt_pkg::DigIdxW-1:0] rd_idx,
	output logic [3:0]                   rd_digit,
	output ufmt_pkg::conv_stat_t         stat
);

	logic [31:0]                  v_q;
	logic [ufmt_pkg::DigIdxW-1:0] nd_q;
	logic                         busy_q;
	logic                         done_q;
	logic [3:0]                   digs_q [ufmt_pkg::MaxDigits];
	logic [63:0]                  prod;
	logic [31:0]                  quot;
	logic [31:0]                  rem;

	assign prod = 64'(v_q) * 64'(ufmt_pkg::RECIP_TEN);
	assign quot = 32'(prod >> ufmt_pkg::RECIP_SHIFT);
	assign rem  = v_q - ((quot << 3) + (quot << 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			nd_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				nd_q   <= '0;
			end else if (busy_q) begin
				nd_q <= nd_q + 1'b1;
				if (quot == 32'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
		end else if (busy_q) begin
			v_q          <= quot;
			digs_q[nd_q] <= rem[3:0];
		end
	end

	assign rd_digit = (rd_idx < ufmt_pkg::DigIdxW'(ufmt_pkg::MaxDigits)) ? digs_q[rd_idx] : 4'd0;
	assign stat.done = done_q;
	assign stat.nd   = nd_q;

endmodule

// ===== sv/ufmt_emit.sv =====
// ----------------------------------------------------------------------------
// Field emitter
// Walks the field one character per cycle, unless the output stalls, into a registered output beat.
// ----------------------------------------------------------------------------
module ufmt_emit #(
	parameter int MAX_FIELD = ufmt_pkg::MaxField,
	localparam int LW = $clog2(MAX_FIELD + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [LW-1:0]                w_sat,
	input  logic [LW-1:0]                p_sat,
	input  logic                         zp,
	input  logic                         lj,
	input  logic [ufmt_pkg::DigIdxW-1:0] nd,
	output logic [ufmt_pkg::DigIdxW-1:0] rd_idx,
	input  logic [3:0]                   rd_digit,
	output logic                         done,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ufmt_pkg::out_t               out_data
);

	logic [LW-1:0] nd_ext;
	logic [LW-1:0] dlen;
	logic [LW-1:0] flen;
	logic [LW-1:0] dlen_q;
	logic [LW-1:0] flen_q;
	logic [LW-1:0] lead_q;
	logic [LW-1:0] nz_q;
	logic [LW-1:0] pos_q;
	logic [LW-1:0] j;
	logic [LW-1:0] didx;
	logic [7:0]    padc_q;
	logic          active_q;
	logic          ovalid_q;
	logic          load;
	logic          is_last;
	logic [7:0]    ch;

	assign nd_ext = LW'(nd);
	assign dlen   = (p_sat > nd_ext) ? p_sat : nd_ext;
	assign flen   = (w_sat > dlen) ? w_sat : dlen;

	assign load    = active_q && (!ovalid_q || out_ready);
	assign is_last = (pos_q == flen_q - 1'b1);
	assign j       = pos_q - lead_q;
	assign didx    = dlen_q - 1'b1 - j;
	assign rd_idx  = didx[ufmt_pkg::DigIdxW-1:0];

	always_comb begin
		if (pos_q < lead_q) begin
			ch = padc_q;
		end else if (j < nz_q) begin
			ch = ufmt_pkg::CHAR_ZERO;
		end else if (j < dlen_q) begin
			ch = ufmt_pkg::CHAR_ZERO + 8'(rd_digit);
		end else begin
			ch = ufmt_pkg::CHAR_SPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ovalid_q <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
				pos_q    <= '0;
			end else if (load) begin
				pos_q <= pos_q + 1'b1;
				if (is_last) begin
					active_q <= 1'b0;
				end
			end
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dlen_q <= dlen;
			flen_q <= flen;
			nz_q   <= dlen - nd_ext;
			lead_q <= lj ? '0 : (flen - dlen);
			padc_q <= (zp && !lj) ? ufmt_pkg::CHAR_ZERO : ufmt_pkg::CHAR_SPACE;
		end
		if (load) begin
			out_data.character <= ch;
			out_data.last      <= is_last;
		end
	end

	assign done      = load && is_last;
	assign out_valid = ovalid_q;

endmodule
